### design/fixed_width_histogram_assert.svh
// -----------------------------------------------------------------------------
// Fixed-width histogram assertion macros
// Concurrent checks sampled on clock, held off while reset is high.
// -----------------------------------------------------------------------------
`ifndef FIXED_WIDTH_HISTOGRAM_ASSERT_SVH
`define FIXED_WIDTH_HISTOGRAM_ASSERT_SVH

// Property must hold at every edge outside reset.
`define FWH_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FWH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/fwh_pkg.sv
// -----------------------------------------------------------------------------
// fwh_pkg
// Shared constants, command codes and control/status types of the histogram.
// -----------------------------------------------------------------------------
package fwh_pkg;

   localparam int NUM_BINS  = 1024;
   localparam int COUNT_W   = 32;
   localparam int DATA_W    = 32;
   localparam int CMD_W     = 2;
   localparam int BIN_IDX_W = $clog2(NUM_BINS);
   localparam int USED_W    = $clog2(NUM_BINS + 1);
   localparam int STEP_W    = $clog2(DATA_W);

   localparam int REQ_TDATA_W = ((DATA_W + BIN_IDX_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((COUNT_W + USED_W + 7) / 8) * 8;

   typedef logic [CMD_W-1:0] cmd_type;

   localparam cmd_type CMD_ADD   = 2'd0;
   localparam cmd_type CMD_READ  = 2'd1;
   localparam cmd_type CMD_CLEAR = 2'd2;

   // 1.0 in Q24.8
   localparam logic [DATA_W-1:0] BIN_WIDTH_RESET = 32'd256;

   typedef struct packed {
      logic load;      // capture the accepted transaction, start the divider
      logic div_step;  // one quotient bit
      logic lookup;    // issue the counter read
      logic finish;    // write back, load the response register
      logic clr_step;  // zero one counter of the sweep
   } ctl_type;

   typedef struct packed {
      logic div_last;  // current step gives the last quotient bit
      logic clr_last;  // current sweep address is the last bin
      logic out_free;  // response register can take a new result
   } stat_type;

endpackage

### design/fwh_ram.sv
// -----------------------------------------------------------------------------
// fwh_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module fwh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/fwh_ctrl.sv
// -----------------------------------------------------------------------------
// fwh_ctrl
// Sequencer: clearing sweep, divide, counter lookup and result hand-off.
// -----------------------------------------------------------------------------
module fwh_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  fwh_pkg::cmd_type  req_cmd,
   output logic              req_ready,
   output fwh_pkg::ctl_type  ctl,
   input  fwh_pkg::stat_type stat
);
   import fwh_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DIVIDE,
      ST_LOOKUP,
      ST_FINISH,
      ST_CLEAR
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            ctl.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               case (req_cmd)
                  CMD_ADD:   state_in = ST_DIVIDE;
                  CMD_READ:  state_in = ST_LOOKUP;
                  CMD_CLEAR: state_in = ST_CLEAR;
                  default:   state_in = ST_FINISH;
               endcase
            end
         end
         ST_DIVIDE: begin
            ctl.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            ctl.lookup = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the response register is free
            if (stat.out_free) begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            ctl.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_FINISH;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/fwh_datapath.sv
// -----------------------------------------------------------------------------
// fwh_datapath
// Bin width register, bit-serial divider, counter RAM and response register.
// -----------------------------------------------------------------------------
module fwh_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [fwh_pkg::DATA_W-1:0]       csr_wdata,
   input  fwh_pkg::cmd_type                 req_cmd,
   input  logic [fwh_pkg::DATA_W-1:0]       req_sample,
   input  logic [fwh_pkg::BIN_IDX_W-1:0]    req_bin_index,
   input  fwh_pkg::ctl_type                 ctl,
   output fwh_pkg::stat_type                stat,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [fwh_pkg::COUNT_W-1:0]      rsp_bin_count,
   output logic [fwh_pkg::USED_W-1:0]       rsp_bins_in_use,
   output logic                             rsp_out_of_range
);
   import fwh_pkg::*;

   localparam logic [STEP_W-1:0]    STEP_LAST = STEP_W'(DATA_W - 1);
   localparam logic [BIN_IDX_W-1:0] ADDR_LAST = BIN_IDX_W'(NUM_BINS - 1);
   localparam logic [DATA_W-1:0]    QUO_LIMIT = DATA_W'(NUM_BINS);

   // control registers
   logic [DATA_W-1:0]    bin_width_ff, bin_width_in;
   logic [USED_W-1:0]    used_bins_ff, used_bins_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [BIN_IDX_W-1:0] clr_addr_ff, clr_addr_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload registers
   cmd_type              cmd_ff, cmd_in;
   logic [BIN_IDX_W-1:0] index_ff, index_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [USED_W-1:0]    used_out_ff, used_out_in;
   logic                 oor_ff, oor_in;

   logic [DATA_W:0]      shifted;
   logic [DATA_W+1:0]    diff;
   logic                 diff_neg;

   logic                 add_oor;
   logic                 read_oor;
   logic [USED_W-1:0]    q_plus;
   logic [COUNT_W-1:0]   rd_data;
   logic [COUNT_W-1:0]   count_inc;

   logic                 ram_wr_en;
   logic [BIN_IDX_W-1:0] ram_wr_addr;
   logic [COUNT_W-1:0]   ram_wr_data;
   logic [BIN_IDX_W-1:0] ram_rd_addr;

   // restoring division, one quotient bit per step
   assign shifted  = {rem_ff, quo_ff[DATA_W-1]};
   assign diff     = {1'b0, shifted} - {2'b00, bin_width_ff};
   assign diff_neg = diff[DATA_W+1];

   assign add_oor   = (quo_ff >= QUO_LIMIT);
   assign q_plus    = USED_W'({1'b0, quo_ff[BIN_IDX_W-1:0]}) + USED_W'(1);
   assign read_oor  = (USED_W'({1'b0, index_ff}) >= used_bins_ff);
   assign count_inc = (rd_data == '1) ? rd_data : rd_data + COUNT_W'(1);

   assign ram_wr_en   = ctl.clr_step | (ctl.finish & (cmd_ff == CMD_ADD) & ~add_oor);
   assign ram_wr_addr = ctl.clr_step ? clr_addr_ff : quo_ff[BIN_IDX_W-1:0];
   assign ram_wr_data = ctl.clr_step ? '0 : count_inc;
   assign ram_rd_addr = (cmd_ff == CMD_ADD) ? quo_ff[BIN_IDX_W-1:0] : index_ff;

   fwh_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (NUM_BINS)
   ) u_counters (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ctl.lookup),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      bin_width_in = csr_we ? csr_wdata : bin_width_ff;
      cmd_in       = cmd_ff;
      index_in     = index_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      clr_addr_in  = clr_addr_ff;

      if (ctl.load) begin
         cmd_in   = req_cmd;
         index_in = req_bin_index;
         quo_in   = req_sample;
         rem_in   = '0;
         step_in  = '0;
      end else if (ctl.div_step) begin
         rem_in  = diff_neg ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
         quo_in  = {quo_ff[DATA_W-2:0], ~diff_neg};
         step_in = step_ff + STEP_W'(1);
      end

      if (ctl.clr_step) begin
         clr_addr_in = (clr_addr_ff == ADDR_LAST) ? '0 : clr_addr_ff + BIN_IDX_W'(1);
      end
   end

   // result of the finished transaction
   always_comb begin
      used_bins_in = used_bins_ff;
      count_in     = '0;
      oor_in       = 1'b0;
      case (cmd_ff)
         CMD_ADD: begin
            if (add_oor) begin
               oor_in = 1'b1;
            end else begin
               count_in = count_inc;
               if (q_plus > used_bins_ff) begin
                  used_bins_in = q_plus;
               end
            end
         end
         CMD_READ: begin
            if (read_oor) begin
               oor_in = 1'b1;
            end else begin
               count_in = rd_data;
            end
         end
         CMD_CLEAR: begin
            used_bins_in = '0;
         end
         default: begin
         end
      endcase
      used_out_in = used_bins_in;
      if (!ctl.finish) begin
         used_bins_in = used_bins_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_width_ff <= BIN_WIDTH_RESET;
         used_bins_ff <= '0;
         step_ff      <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bin_width_ff <= bin_width_in;
         used_bins_ff <= used_bins_in;
         step_ff      <= step_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      index_ff <= index_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      if (ctl.finish) begin
         count_ff    <= count_in;
         used_out_ff <= used_out_in;
         oor_ff      <= oor_in;
      end
   end

   assign stat.div_last = (step_ff == STEP_LAST);
   assign stat.clr_last = (clr_addr_ff == ADDR_LAST);
   assign stat.out_free = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bin_count    = count_ff;
   assign rsp_bins_in_use  = used_out_ff;
   assign rsp_out_of_range = oor_ff;

endmodule

### design/fixed_width_histogram.sv
// -----------------------------------------------------------------------------
// fixed_width_histogram
// Fixed-bin-width histogram: add samples, read bin counts, clear all bins.
// -----------------------------------------------------------------------------
// Usage:
//   req_* carries one command transaction (add, read or clear) per handshake;
//   rsp_* returns exactly one result transaction for each command, in order.
//   csr_we/csr_wdata write the bin width (unsigned Q24.8); write it only while
//   no command is outstanding.
// Sequence per command, from acceptance to rsp_tvalid:
//   add   : 32 steps of the bit-serial divider, one counter RAM read and a
//           write-back; no new command is taken until the result is handed off.
//   read  : RAM read then result.
//   clear : the counter RAM is swept one bin per cycle.
//   other : goes straight to the result.
// Reset: bin width returns to 1.0 and every counter is zeroed by a sweep of
//   the RAM; req_tready stays low until the sweep completes.
// Stall: the result sits in an output register; a command finished while it is
//   full and rsp_tready is low waits in the sequencer and req_tready stays low.
// -----------------------------------------------------------------------------
`include "fixed_width_histogram_assert.svh"

module fixed_width_histogram (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_we,
   input  logic [fwh_pkg::DATA_W-1:0]         csr_wdata,   // bin_width
   // command transactions
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [fwh_pkg::REQ_TDATA_W-1:0]    req_tdata,   // sample[31:0], bin_index[41:32]
   input  logic [fwh_pkg::CMD_W-1:0]          req_tuser,   // cmd[1:0]
   // result transactions
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [fwh_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // bin_count[31:0], bins_in_use[42:32]
   output logic                               rsp_tuser    // out_of_range
);
   import fwh_pkg::*;

   ctl_type              ctl;
   stat_type             stat;
   logic [COUNT_W-1:0]   bin_count;
   logic [USED_W-1:0]    bins_in_use;

   // sequencer: owns req_tready and steps the datapath through one command at a time
   fwh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_cmd   (req_tuser),
      .req_ready (req_tready),
      .ctl       (ctl),
      .stat      (stat)
   );

   // datapath: divider, counter RAM, bins-in-use and the result register
   fwh_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_cmd          (req_tuser),
      .req_sample       (req_tdata[DATA_W-1:0]),
      .req_bin_index    (req_tdata[DATA_W +: BIN_IDX_W]),
      .ctl              (ctl),
      .stat             (stat),
      .rsp_ready        (rsp_tready),
      .rsp_valid        (rsp_tvalid),
      .rsp_bin_count    (bin_count),
      .rsp_bins_in_use  (bins_in_use),
      .rsp_out_of_range (rsp_tuser)
   );

   // pack the result, zero-fill to whole bytes
   assign rsp_tdata = RSP_TDATA_W'({bins_in_use, bin_count});

   // a result only enters the output register when it is free
   `FWH_ASSERT_ALWAYS(a_finish_free, !ctl.finish || stat.out_free, "result overwritten")
   // the sweep never overlaps divider or lookup work
   `FWH_ASSERT_ALWAYS(a_sweep_alone,
      !(ctl.clr_step && (ctl.div_step || ctl.lookup || ctl.finish)), "sweep overlaps a command")
   // one command at a time: accept drops ready for the next cycle
   `FWH_ASSERT_NEXT(a_one_cmd, req_tvalid && req_tready, !req_tready,
      "second command taken while busy")
   // a flagged result never carries a count
   `FWH_ASSERT_ALWAYS(a_oor_zero, !(rsp_tvalid && rsp_tuser) || (bin_count == '0),
      "flagged result with count")

endmodule
